@@ hdl/tile_scroll_column_streamer_core_defines.svh @@
// Assertion macros shared by the scroll engine RTL.
`ifndef TILE_SCROLL_COLUMN_STREAMER_CORE_DEFINES_SVH
`define TILE_SCROLL_COLUMN_STREAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TSCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TSCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tscs_pkg.sv @@
package tscs_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_REQ,
    S_STAT,
    S_QUERY
  } tscs_state_t;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_RESET  = 3'd1;
  localparam logic [2:0] MODE_PAUSE  = 3'd2;
  localparam logic [2:0] MODE_RESUME = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  localparam logic CFG_SPEED  = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  // 8 pixels of 8.8 fixed point per column, 160 pixels of view
  localparam int unsigned COL_SHIFT = 11;
  localparam logic [31:0] VIEW_FX   = 32'd40960;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } tscs_alu_op_t;

endpackage

@@ hdl/tscs_if.sv @@
interface tscs_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  start_column;
  logic [31:0] world_position;

  modport source (output valid, mode, start_column, world_position, input ready);
  modport sink (input valid, mode, start_column, world_position, output ready);
endinterface

interface tscs_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] tile_slot;
  logic [7:0] world_column;
  logic [7:0] scroll_pixel;
  logic [4:0] scroll_column;
  logic [7:0] screen_x;
  logic       offscreen;
  logic       last;

  modport source (
    output valid, kind, tile_slot, world_column, scroll_pixel, scroll_column,
           screen_x, offscreen, last,
    input  ready
  );
  modport sink (
    input  valid, kind, tile_slot, world_column, scroll_pixel, scroll_column,
           screen_x, offscreen, last,
    output ready
  );
endinterface

@@ hdl/tscs_alu.sv @@
module tscs_alu
  import tscs_pkg::*;
(
  input  tscs_alu_op_t op,
  output logic [32:0]  res
);

  logic [31:0] b_eff;

  // sub: a + ~b + 1, res[32] set when a >= b; add: res[32] is the wrap carry
  assign b_eff = op.sub ? ~op.b : op.b;
  assign res   = {1'b0, op.a} + {1'b0, b_eff} + {32'd0, op.sub};

endmodule

@@ hdl/tile_scroll_column_streamer_core.sv @@
// Horizontal scroll engine. One item is taken at a time; item.ready is high only
// while the sequencer is idle, and results leave through a single output
// register at up to one per cycle while result.ready is high. A query passes
// S_QUERY; a tick S_CALC, S_REQ once per column boundary crossed (up to 32)
// and S_STAT; a reset S_CALC, S_REQ once per column of VIEW_COLUMNS+1 and
// S_STAT; other modes S_CALC and S_STAT, each output state waiting on result
// stalls. A single 33-bit adder serves the tick position update and the query
// offset subtraction; the 8-bit column request counter steps once per S_REQ pass.
`include "tile_scroll_column_streamer_core_defines.svh"

module tile_scroll_column_streamer_core
  import tscs_pkg::*;
#(
  parameter int unsigned VIEW_COLUMNS      = 20,
  parameter int unsigned LOOKAHEAD_COLUMNS = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  tscs_item_if.sink     item,
  tscs_result_if.source result
);

  tscs_state_t state, state_next;

  logic [15:0] speed;
  logic        req_enable;

  logic [31:0] position, position_next;
  logic [7:0]  left_column, left_column_next;
  logic        paused, paused_next;

  logic [2:0]  mode;
  logic [7:0]  start_column;
  logic [31:0] world_position;

  logic [5:0]  req_count, req_count_next;
  logic [7:0]  req_col, req_col_next;
  logic        adv_left, adv_left_next;

  logic        out_valid, out_valid_next;
  logic [1:0]  out_kind, out_kind_next;
  logic [4:0]  out_slot, out_slot_next;
  logic [7:0]  out_wcol, out_wcol_next;
  logic [7:0]  out_px, out_px_next;
  logic [4:0]  out_pcol, out_pcol_next;
  logic [7:0]  out_sx, out_sx_next;
  logic        out_off, out_off_next;
  logic        out_last, out_last_next;

  tscs_alu_op_t alu_op;
  logic [32:0]  alu_res;
  logic [5:0]   crossings;
  logic         load_ok;
  logic         accept;

  tscs_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  assign accept  = item.valid && item.ready;
  assign load_ok = !out_valid || result.ready;
  assign item.ready = (state == S_IDLE);

  always_comb begin
    if (state == S_QUERY) begin
      alu_op.a   = world_position;
      alu_op.b   = position;
      alu_op.sub = 1'b1;
    end else begin
      alu_op.a   = position;
      alu_op.b   = {16'd0, speed};
      alu_op.sub = 1'b0;
    end
  end

  // crossings stay below 64, so the low column bits give the count
  assign crossings = alu_res[32] ? 6'd0 :
                     alu_res[COL_SHIFT+5:COL_SHIFT] - position[COL_SHIFT+5:COL_SHIFT];

  always_comb begin
    state_next       = state;
    position_next    = position;
    left_column_next = left_column;
    paused_next      = paused;
    req_count_next   = req_count;
    req_col_next     = req_col;
    adv_left_next    = adv_left;
    out_valid_next   = out_valid && !result.ready;
    out_kind_next    = out_kind;
    out_slot_next    = out_slot;
    out_wcol_next    = out_wcol;
    out_px_next      = out_px;
    out_pcol_next    = out_pcol;
    out_sx_next      = out_sx;
    out_off_next     = out_off;
    out_last_next    = out_last;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (item.mode == MODE_QUERY) ? S_QUERY : S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_STAT;
        priority if (mode == MODE_TICK) begin
          if (!paused) begin
            position_next  = alu_res[31:0];
            req_count_next = crossings;
            req_col_next   = left_column + 8'(LOOKAHEAD_COLUMNS + 1);
            adv_left_next  = 1'b1;
            if (crossings != 6'd0) begin
              state_next = S_REQ;
            end
          end
        end else if (mode == MODE_RESET) begin
          left_column_next = start_column;
          position_next    = {13'd0, start_column, 11'd0};
          paused_next      = 1'b0;
          req_count_next   = 6'(VIEW_COLUMNS + 1);
          req_col_next     = start_column;
          adv_left_next    = 1'b0;
          state_next       = S_REQ;
        end else if (mode == MODE_PAUSE) begin
          paused_next = 1'b1;
        end else if (mode == MODE_RESUME) begin
          paused_next = 1'b0;
        end else begin
          paused_next = paused;
        end
      end
      S_REQ: begin
        if (!req_enable || load_ok) begin
          if (req_enable) begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_REQUEST;
            out_slot_next  = req_col[4:0];
            out_wcol_next  = req_col;
            out_px_next    = 8'd0;
            out_pcol_next  = 5'd0;
            out_sx_next    = 8'd0;
            out_off_next   = 1'b0;
            out_last_next  = 1'b0;
          end
          req_count_next = req_count - 6'd1;
          req_col_next   = req_col + 8'd1;
          if (adv_left) begin
            left_column_next = left_column + 8'd1;
          end
          if (req_count == 6'd1) begin
            state_next = S_STAT;
          end
        end
      end
      S_STAT: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_STATUS;
          out_slot_next  = 5'd0;
          out_wcol_next  = 8'd0;
          out_px_next    = position[15:8];
          out_pcol_next  = position[15:11];
          out_sx_next    = 8'd0;
          out_off_next   = 1'b0;
          out_last_next  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_QUERY: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_QUERY;
          out_slot_next  = 5'd0;
          out_wcol_next  = 8'd0;
          out_px_next    = 8'd0;
          out_pcol_next  = 5'd0;
          out_last_next  = 1'b1;
          if (!alu_res[32] || alu_res[31:0] >= VIEW_FX) begin
            out_sx_next  = 8'd0;
            out_off_next = 1'b1;
          end else begin
            out_sx_next  = alu_res[15:8];
            out_off_next = 1'b0;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed       <= 16'd0;
      req_enable  <= 1'b0;
      position    <= 32'd0;
      left_column <= 8'd0;
      paused      <= 1'b0;
      req_count   <= 6'd0;
      adv_left    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED:  speed      <= cfg_data;
          CFG_ENABLE: req_enable <= cfg_data[0];
          default:    speed      <= speed;
        endcase
      end
      position    <= position_next;
      left_column <= left_column_next;
      paused      <= paused_next;
      req_count   <= req_count_next;
      adv_left    <= adv_left_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode           <= item.mode;
      start_column   <= item.start_column;
      world_position <= item.world_position;
    end
    req_col  <= req_col_next;
    out_kind <= out_kind_next;
    out_slot <= out_slot_next;
    out_wcol <= out_wcol_next;
    out_px   <= out_px_next;
    out_pcol <= out_pcol_next;
    out_sx   <= out_sx_next;
    out_off  <= out_off_next;
    out_last <= out_last_next;
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_kind;
  assign result.tile_slot     = out_slot;
  assign result.world_column  = out_wcol;
  assign result.scroll_pixel  = out_px;
  assign result.scroll_column = out_pcol;
  assign result.screen_x      = out_sx;
  assign result.offscreen     = out_off;
  assign result.last          = out_last;

  `TSCS_ASSERT_NEXT(a_busy_after_accept, accept, !item.ready, "ready after accept")
  `TSCS_ASSERT_NOW(a_req_count, state == S_REQ, req_count != 6'd0, "request loop with zero count")
  `TSCS_ASSERT_NOW(a_req_not_last, out_valid && out_kind == KIND_REQUEST, !out_last, "request marked last")
  `TSCS_ASSERT_NEXT(a_idle_hold, state == S_IDLE, $stable(position), "position moved while idle")

endmodule
